// ----- rtl/rmq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and helpers for the rotation matrix to quaternion block.
// No dependencies.
package rmq_pkg;

  localparam int FRAC_BITS = 27;
  localparam int DATA_W    = 32;
  localparam int THR_W     = 28;
  // Radicand in the input format is positive and below 2^33
  localparam int R_W       = 33;
  // Signed sums of three elements plus one
  localparam int RS_W      = 35;
  // Magnitude of a difference or sum of two elements
  localparam int MAG_W     = 33;
  localparam int RAD_W     = R_W + FRAC_BITS - 2;
  localparam int H_W       = (RAD_W + 1) / 2;
  localparam int DEN_W     = H_W + 2;
  // Quotient bits kept before saturation; larger quotients flag overflow
  localparam int QW        = 33;
  localparam int DIVN_W    = MAG_W + FRAC_BITS + 1;
  localparam int CMP_W     = (DEN_W + QW > DIVN_W) ? DEN_W + QW : DIVN_W;

  localparam logic [DATA_W-1:0] ONE_Q   = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [THR_W-1:0]  THR_RESET = THR_W'(1);

  // Branch code doubles as the quaternion slot that takes the half root
  typedef enum logic [1:0] {
    BR_X     = 2'd0,
    BR_Y     = 2'd1,
    BR_Z     = 2'd2,
    BR_TRACE = 2'd3
  } br_t;

  // Payload carried alongside the square root
  typedef struct packed {
    logic                       degen;
    br_t                        br;
    logic [2:0]                 neg;
    logic [2:0][MAG_W-1:0]      mag;
    logic [RAD_W-1:0]           rem;
    logic [H_W-1:0]             root;
  } sq_t;

  // Payload carried alongside the three dividers
  typedef struct packed {
    logic                       degen;
    br_t                        br;
    logic [H_W-1:0]             h;
    logic [DEN_W-1:0]           den;
    logic [2:0]                 neg;
    logic [2:0]                 ovf;
    logic [2:0][DIVN_W-1:0]     rem;
    logic [2:0][QW-1:0]         q;
  } dv_t;

  // Magnitude of a signed element
  function automatic logic [DATA_W:0] mag_of(input logic [DATA_W-1:0] v);
    logic [DATA_W:0] ext;
    ext = {v[DATA_W-1], v};
    return v[DATA_W-1] ? ((DATA_W+1)'(0) - ext) : ext;
  endfunction

endpackage

// ----- rtl/rmq_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels for matrix input and quaternion output.
// Depends on rmq_pkg for widths.
interface rmq_in_if;
  import rmq_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] m00, m01, m02, m03;
  logic [DATA_W-1:0] m10, m11, m12, m13;
  logic [DATA_W-1:0] m20, m21, m22, m23;
  modport source (output valid, m00, m01, m02, m03, m10, m11, m12, m13,
                  m20, m21, m22, m23, input ready);
  modport sink   (input valid, m00, m01, m02, m03, m10, m11, m12, m13,
                  m20, m21, m22, m23, output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] quat_x, quat_y, quat_z, quat_w;
  logic              degenerate;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, degenerate,
                  input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, degenerate,
                  output ready);
endinterface

// ----- rtl/rotation_matrix_to_quaternion.sv -----
`timescale 1ns / 1ps
// Top level: fixed point rotation matrix to quaternion, fully pipelined.
// Depends on rmq_pkg and the channel interfaces in rmq_if.sv.
//
//   channel   direction  handshake     payload
//   in_mat    in         valid/ready   m00..m23, signed Q4.27
//   out_quat  out        valid/ready   quat_x..quat_w, degenerate
//   cfg       in         cfg_we        cfg_wdata = near-zero threshold
//
// One transaction per cycle while the output accepts; the pipeline holds one
// square root stage per root bit and one divider stage per quotient bit.
// All stages advance together when the output register is empty or taken;
// a stall holds every stage in place.
// Reset (rst_n, synchronous) clears the valid bits and sets the threshold to 1.
module rotation_matrix_to_quaternion (
  input  logic                        clk,
  input  logic                        rst_n,
  rmq_in_if.sink                      in_mat,
  rmq_out_if.source                   out_quat,
  input  logic                        cfg_we,
  input  logic [rmq_pkg::THR_W-1:0]   cfg_wdata
);
  import rmq_pkg::*;

  logic en;
  logic [THR_W-1:0] thr_r;

  // Advance the whole pipeline when the output slot frees up
  assign en           = !out_quat.valid || out_quat.ready;
  assign in_mat.ready = en;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // ---------------- Stage 1: row check, trace, first diagonal compare
  logic [11:0][DATA_W-1:0] in_m;
  logic [2:0]              row_small;
  logic                    s1_v_r, s1_zr_r, s1_gt10_r;
  logic [8:0][DATA_W-1:0]  s1_m_r;
  logic signed [RS_W-1:0]  s1_tr_r;

  assign in_m = {in_mat.m23, in_mat.m22, in_mat.m21, in_mat.m20,
                 in_mat.m13, in_mat.m12, in_mat.m11, in_mat.m10,
                 in_mat.m03, in_mat.m02, in_mat.m01, in_mat.m00};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_small[r] = 1'b1;
      for (int c = 0; c < 4; c++) begin
        if (mag_of(in_m[r*4+c]) > (DATA_W+1)'(thr_r)) row_small[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_mat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_zr_r   <= |row_small;
      s1_gt10_r <= $signed(in_mat.m11) > $signed(in_mat.m00);
      s1_m_r    <= {in_mat.m22, in_mat.m21, in_mat.m20,
                    in_mat.m12, in_mat.m11, in_mat.m10,
                    in_mat.m02, in_mat.m01, in_mat.m00};
      s1_tr_r   <= RS_W'($signed(in_mat.m00)) + RS_W'($signed(in_mat.m11))
                 + RS_W'($signed(in_mat.m22));
    end
  end

  // ---------------- Stage 2: branch, radicand, numerators
  logic signed [DATA_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  br_t                      br;
  logic signed [RS_W-1:0]   rad_s;
  logic signed [MAG_W-1:0]  num [3];
  logic                     s2_degen;
  sq_t                      s2_d;

  assign {a22, a21, a20, a12, a11, a10, a02, a01, a00} = s1_m_r;

  function automatic logic signed [MAG_W-1:0] sum2(input logic signed [DATA_W-1:0] p,
                                                   input logic signed [DATA_W-1:0] q);
    return MAG_W'(p) + MAG_W'(q);
  endfunction

  function automatic logic signed [MAG_W-1:0] dif2(input logic signed [DATA_W-1:0] p,
                                                   input logic signed [DATA_W-1:0] q);
    return MAG_W'(p) - MAG_W'(q);
  endfunction

  always_comb begin
    logic signed [DATA_W-1:0] dmax;
    logic signed [RS_W-1:0]   one_s;
    one_s = RS_W'(ONE_Q);
    dmax  = s1_gt10_r ? a11 : a00;
    // Pick the branch: positive trace first, then the largest diagonal
    if (s1_tr_r > 0)       br = BR_TRACE;
    else if (a22 > dmax)   br = BR_Z;
    else if (s1_gt10_r)    br = BR_Y;
    else                   br = BR_X;

    // Numerators go in ascending order of the slots other than br
    unique case (br)
      BR_TRACE: begin
        rad_s  = s1_tr_r + one_s;
        num[0] = dif2(a12, a21);
        num[1] = dif2(a20, a02);
        num[2] = dif2(a01, a10);
      end
      BR_X: begin
        rad_s  = RS_W'(a00) - RS_W'(a11) - RS_W'(a22) + one_s;
        num[0] = sum2(a01, a10);
        num[1] = sum2(a02, a20);
        num[2] = dif2(a12, a21);
      end
      BR_Y: begin
        rad_s  = RS_W'(a11) - RS_W'(a22) - RS_W'(a00) + one_s;
        num[0] = sum2(a10, a01);
        num[1] = sum2(a12, a21);
        num[2] = dif2(a20, a02);
      end
      default: begin
        rad_s  = RS_W'(a22) - RS_W'(a00) - RS_W'(a11) + one_s;
        num[0] = sum2(a20, a02);
        num[1] = sum2(a21, a12);
        num[2] = dif2(a01, a10);
      end
    endcase

    s2_degen   = s1_zr_r || (rad_s <= 0);
    s2_d.degen = s2_degen;
    s2_d.br    = br;
    for (int l = 0; l < 3; l++) begin
      s2_d.neg[l] = num[l][MAG_W-1];
      s2_d.mag[l] = num[l][MAG_W-1] ? (MAG_W'(0) - MAG_W'(num[l])) : MAG_W'(num[l]);
    end
    // Feed a zero radicand on the identity path
    s2_d.rem  = s2_degen ? '0 : (RAD_W'(rad_s[R_W-1:0]) << (FRAC_BITS - 2));
    s2_d.root = '0;
  end

  // ---------------- Square root: one result bit per stage
  sq_t  sq_r [H_W+1];
  logic sq_v_r [H_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= s2_d;
    end
  end

  for (genvar t = 0; t < H_W; t++) begin : g_sqrt
    localparam int B = H_W - 1 - t;
    logic [RAD_W:0] sub;
    sq_t            nxt;

    always_comb begin
      sub = (RAD_W+1)'({sq_r[t].root, 1'b0} << B) + ((RAD_W+1)'(1) << (2 * B));
      nxt = sq_r[t];
      // Keep the bit when the remainder covers the square increment
      if ((RAD_W+1)'(sq_r[t].rem) >= sub) begin
        nxt.rem     = RAD_W'((RAD_W+1)'(sq_r[t].rem) - sub);
        nxt.root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[t+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[t+1] <= sq_v_r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[t+1] <= nxt;
      end
    end
  end

  // ---------------- Divider setup: rounded numerator, overflow check
  dv_t dv_d;

  always_comb begin
    logic [DIVN_W-1:0] n;
    dv_d.degen = sq_r[H_W].degen || (sq_r[H_W].root == '0);
    dv_d.br    = sq_r[H_W].br;
    dv_d.h     = sq_r[H_W].root;
    dv_d.den   = {sq_r[H_W].root, 2'b00};
    dv_d.neg   = sq_r[H_W].neg;
    for (int l = 0; l < 3; l++) begin
      n = (DIVN_W'(sq_r[H_W].mag[l]) << FRAC_BITS) + DIVN_W'({sq_r[H_W].root, 1'b0});
      dv_d.rem[l] = n;
      dv_d.ovf[l] = CMP_W'(n >> QW) >= CMP_W'(dv_d.den);
      dv_d.q[l]   = '0;
    end
  end

  dv_t  dv_r [QW+1];
  logic dv_v_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[H_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv_d;
    end
  end

  // ---------------- Three dividers: one quotient bit per stage
  for (genvar t = 0; t < QW; t++) begin : g_div
    localparam int B = QW - 1 - t;
    logic [CMP_W-1:0] trial;
    dv_t              nxt;

    always_comb begin
      trial = CMP_W'(dv_r[t].den) << B;
      nxt   = dv_r[t];
      for (int l = 0; l < 3; l++) begin
        if (CMP_W'(dv_r[t].rem[l]) >= trial) begin
          nxt.rem[l]  = DIVN_W'(CMP_W'(dv_r[t].rem[l]) - trial);
          nxt.q[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[t+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[t+1] <= dv_v_r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[t+1] <= nxt;
      end
    end
  end

  // ---------------- Saturate, place into slots, output register
  logic [2:0][DATA_W-1:0] lane_q;
  logic [3:0][DATA_W-1:0] slot_q;
  logic                   out_v_r, out_dg_r;
  logic [3:0][DATA_W-1:0] out_q_r;

  always_comb begin
    logic [QW-1:0] q;
    logic [1:0]    hs;
    for (int l = 0; l < 3; l++) begin
      q = dv_r[QW].q[l];
      if (dv_r[QW].neg[l]) begin
        if (dv_r[QW].ovf[l] || q > QW'(SAT_NEG)) lane_q[l] = SAT_NEG;
        else                                     lane_q[l] = DATA_W'(0) - q[DATA_W-1:0];
      end else begin
        if (dv_r[QW].ovf[l] || q > QW'(SAT_POS)) lane_q[l] = SAT_POS;
        else                                     lane_q[l] = q[DATA_W-1:0];
      end
    end
    hs = dv_r[QW].br;
    for (int s = 0; s < 4; s++) begin
      if (dv_r[QW].degen)   slot_q[s] = (s == 3) ? ONE_Q : '0;
      else if (2'(s) == hs) slot_q[s] = DATA_W'(dv_r[QW].h);
      else if (2'(s) < hs)  slot_q[s] = lane_q[s];
      else                  slot_q[s] = lane_q[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q_r  <= slot_q;
      out_dg_r <= dv_r[QW].degen;
    end
  end

  assign out_quat.valid      = out_v_r;
  assign out_quat.quat_x     = out_q_r[0];
  assign out_quat.quat_y     = out_q_r[1];
  assign out_quat.quat_z     = out_q_r[2];
  assign out_quat.quat_w     = out_q_r[3];
  assign out_quat.degenerate = out_dg_r;

endmodule

// ----- tb/rotation_matrix_to_quaternion_test.sv -----
`timescale 1ns / 1ps
// Testbench for rotation_matrix_to_quaternion: directed table, then random matrices,
// checked field by field against an in-bench fixed point predictor.
// Depends on rmq_pkg, rmq_if.sv and the block itself.
module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  typedef logic [DATA_W-1:0] elem_t;

  typedef struct {
    elem_t x, y, z, w;
    logic  degen;
  } quat_t;

  typedef struct {
    elem_t e[12];
    bit    known;
    quat_t q;
  } mat_row_t;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 90;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 190;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mat   (in_ch),
    .out_quat (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  quat_t      quat_pending[$];
  mat_row_t   table_rows[$];
  logic [THR_W-1:0] thr_shadow;
  int  errors;
  int  cycles;
  bit  idle_on;
  bit  long_hold_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag(input longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  // num * one / (4h), round half away from zero, saturate
  function automatic elem_t ratio(input longint num, input longint unsigned h);
    longint unsigned den;
    longint unsigned q;
    den = h << 2;
    q = ((mag(num) << FRAC_BITS) + (den >> 1)) / den;
    if (num < 0) return (q > 64'h8000_0000) ? SAT_NEG : elem_t'(-longint'(q));
    return (q > 64'h7FFF_FFFF) ? SAT_POS : elem_t'(q);
  endfunction

  function automatic quat_t shepperd(input elem_t e[12], input logic [THR_W-1:0] thr);
    longint m[3][4];
    elem_t  c[4];
    quat_t  r;
    longint one, tr, rad;
    longint unsigned h;
    bit zero_row, all_small;
    int i, j, k;
    one = longint'(1) << FRAC_BITS;
    zero_row = 0;
    for (int a = 0; a < 3; a++) begin
      all_small = 1;
      for (int b = 0; b < 4; b++) begin
        m[a][b] = longint'(signed'(e[a*4+b]));
        if (mag(m[a][b]) > thr) all_small = 0;
      end
      if (all_small) zero_row = 1;
    end
    r.x = '0; r.y = '0; r.z = '0; r.w = ONE_Q; r.degen = 1'b1;
    if (zero_row) return r;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      h = root64(longint'(tr + one) << (FRAC_BITS - 2));
      if (h == 0) return r;
      r.w = elem_t'(h);
      r.x = ratio(m[1][2] - m[2][1], h);
      r.y = ratio(m[2][0] - m[0][2], h);
      r.z = ratio(m[0][1] - m[1][0], h);
      r.degen = 1'b0;
      return r;
    end
    i = 0;
    if (m[1][1] > m[0][0]) i = 1;
    if (m[2][2] > m[i][i]) i = 2;
    j = (i + 1) % 3;
    k = (j + 1) % 3;
    rad = m[i][i] - m[j][j] - m[k][k] + one;
    if (rad <= 0) return r;
    h = root64(longint'(rad) << (FRAC_BITS - 2));
    if (h == 0) return r;
    c[i] = elem_t'(h);
    c[3] = ratio(m[j][k] - m[k][j], h);
    c[j] = ratio(m[i][j] + m[j][i], h);
    c[k] = ratio(m[i][k] + m[k][i], h);
    r.x = c[0]; r.y = c[1]; r.z = c[2]; r.w = c[3];
    r.degen = 1'b0;
    return r;
  endfunction

  task automatic report(input string what, input elem_t got, input elem_t want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    quat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (quat_pending.size() == 0) begin
        report("unexpected result", out_ch.quat_x, '0);
      end else begin
        want = quat_pending.pop_front();
        if (out_ch.quat_x !== want.x) report("quat_x", out_ch.quat_x, want.x);
        if (out_ch.quat_y !== want.y) report("quat_y", out_ch.quat_y, want.y);
        if (out_ch.quat_z !== want.z) report("quat_z", out_ch.quat_z, want.z);
        if (out_ch.quat_w !== want.w) report("quat_w", out_ch.quat_w, want.w);
        if (out_ch.degenerate !== want.degen)
          report("degenerate", elem_t'(out_ch.degenerate), elem_t'(want.degen));
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        if (hold == 0) out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 6);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one matrix, hold until accepted, then queue its expectation
  task automatic send(input mat_row_t row);
    quat_t want;
    in_ch.valid <= 1'b1;
    in_ch.m00 <= row.e[0];  in_ch.m01 <= row.e[1];
    in_ch.m02 <= row.e[2];  in_ch.m03 <= row.e[3];
    in_ch.m10 <= row.e[4];  in_ch.m11 <= row.e[5];
    in_ch.m12 <= row.e[6];  in_ch.m13 <= row.e[7];
    in_ch.m20 <= row.e[8];  in_ch.m21 <= row.e[9];
    in_ch.m22 <= row.e[10]; in_ch.m23 <= row.e[11];
    want = row.known ? row.q : shepperd(row.e, thr_shadow);
    do @(posedge clk); while (!in_ch.ready);
    quat_pending.push_back(want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (quat_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_thr(input logic [THR_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_shadow = v;
  endtask

  function automatic elem_t near_one();
    return elem_t'(int'($urandom_range(0, 2 * 32'h0800_0000)) - int'(ONE_Q));
  endfunction

  function automatic mat_row_t random_mat();
    mat_row_t row;
    int kind, zr, lim;
    elem_t picks[6];
    row.known = 0;
    kind = $urandom_range(0, 9);
    picks[0] = SAT_NEG; picks[1] = SAT_POS; picks[2] = '0;
    picks[3] = ONE_Q;   picks[4] = -ONE_Q;  picks[5] = $urandom;
    for (int n = 0; n < 12; n++) begin
      case (kind)
        0: begin
          row.e[n] = $urandom;
        end
        1: begin
          row.e[n] = picks[$urandom_range(0, 5)];
        end
        default: begin
          // Rotation-like: diagonal and off-diagonal within about plus or minus one
          row.e[n] = near_one();
          if ($urandom_range(0, 3) == 0) row.e[n] = elem_t'(signed'(row.e[n]) >>> 2);
        end
      endcase
    end
    // Drop one row into the near-zero band now and then
    if ($urandom_range(0, 7) == 0) begin
      zr = $urandom_range(0, 2);
      lim = (thr_shadow > 28'h100_0000) ? 32'h100_0000 : thr_shadow;
      for (int n = 0; n < 4; n++) begin
        row.e[zr*4+n] = elem_t'($urandom_range(0, lim));
        if ($urandom_range(0, 1)) row.e[zr*4+n] = -row.e[zr*4+n];
        if ($urandom_range(0, 9) == 0) row.e[zr*4+n] = elem_t'(lim + 1);
      end
    end
    return row;
  endfunction

  function automatic mat_row_t diag_row(input elem_t a, input elem_t b, input elem_t c);
    mat_row_t row;
    for (int n = 0; n < 12; n++) row.e[n] = '0;
    row.e[0] = a; row.e[5] = b; row.e[10] = c;
    row.known = 0;
    return row;
  endfunction

  // Directed stimulus table
  task automatic build_table();
    mat_row_t row;
    quat_t ident, degen;
    ident.x = '0; ident.y = '0; ident.z = '0; ident.w = ONE_Q; ident.degen = 1'b0;
    degen = ident; degen.degen = 1'b1;
    row = diag_row(ONE_Q, ONE_Q, ONE_Q);  row.known = 1; row.q = ident; table_rows.push_back(row);
    row = diag_row('0, '0, '0);           row.known = 1; row.q = degen; table_rows.push_back(row);
    // Only row 1 sits at the threshold
    row = diag_row(ONE_Q, elem_t'(1), ONE_Q);
    row.e[4] = -1; row.e[6] = 1; row.e[7] = -1;
    row.known = 1; row.q = degen; table_rows.push_back(row);
    // Just above threshold: not degenerate
    row = diag_row(ONE_Q, elem_t'(2), ONE_Q); table_rows.push_back(row);
    // Half-turns about each axis pick each diagonal branch
    table_rows.push_back(diag_row(ONE_Q, -ONE_Q, -ONE_Q));
    table_rows.push_back(diag_row(-ONE_Q, ONE_Q, -ONE_Q));
    table_rows.push_back(diag_row(-ONE_Q, -ONE_Q, ONE_Q));
    // Ties on the diagonal keep the lower index (the last two also have a zero row)
    table_rows.push_back(diag_row(-ONE_Q, -ONE_Q, -ONE_Q));
    table_rows.push_back(diag_row('0, '0, -ONE_Q));
    table_rows.push_back(diag_row(-ONE_Q, '0, '0));
    // Zero trace takes the diagonal path; row 1 is zero, so the result is degenerate
    table_rows.push_back(diag_row(ONE_Q, '0, -ONE_Q));
    // Extremes everywhere
    row = diag_row('0, '0, '0);
    for (int n = 0; n < 12; n++) row.e[n] = SAT_POS;
    table_rows.push_back(row);
    for (int n = 0; n < 12; n++) row.e[n] = SAT_NEG;
    table_rows.push_back(row);
    for (int n = 0; n < 12; n++) row.e[n] = n[0] ? SAT_NEG : SAT_POS;
    table_rows.push_back(row);
    for (int n = 0; n < 12; n++) row.e[n] = n[0] ? SAT_POS : SAT_NEG;
    table_rows.push_back(row);
    // Large off-diagonal elements push the ratios toward saturation
    row = diag_row(SAT_NEG, SAT_NEG, SAT_POS);
    row.e[1] = SAT_POS; row.e[4] = SAT_NEG; row.e[6] = SAT_NEG; row.e[9] = SAT_POS;
    table_rows.push_back(row);
    row = diag_row(elem_t'(1), '0, '0);
    row.e[6] = SAT_POS; row.e[9] = SAT_NEG; row.e[3] = SAT_POS;
    table_rows.push_back(row);
    // Small trace, rotation about z by 90 degrees
    row = diag_row('0, '0, ONE_Q);
    row.e[1] = -ONE_Q; row.e[4] = ONE_Q;
    table_rows.push_back(row);
  endtask

  initial begin
    logic [THR_W-1:0] thr_plan[5];
    errors = 0;
    cycles = 0;
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m03} = '0;
    {in_ch.m10, in_ch.m11, in_ch.m12, in_ch.m13} = '0;
    {in_ch.m20, in_ch.m21, in_ch.m22, in_ch.m23} = '0;
    thr_shadow = THR_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset threshold
    build_table();
    foreach (table_rows[n]) send(table_rows[n]);
    drain();

    thr_plan[0] = '0;
    thr_plan[1] = 28'h800_0000;
    thr_plan[2] = THR_W'($urandom_range(0, 32'h800_0000));
    thr_plan[3] = 28'h7FF_FFFF;
    thr_plan[4] = THR_W'($urandom_range(0, 32'h1000));
    for (int p = 0; p < 5; p++) begin
      write_thr(thr_plan[p]);
      if (p == 1) long_hold_req <= 1'b1;
      if (p == 4) idle_on = 1'b0;
      repeat (PHASE_ITEMS) send(random_mat());
      // Sender pauses until every result is back
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
